>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL; empty bodies in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("lbl failed");
// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("lbl failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> rtl/core/eac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_pkg
// Types and constants of the Ethernet ARP / IPv4 receive classifier.
// ----------------------------------------------------------------------------
package eac_pkg;

   localparam int MAX_FRAME_BYTES = 2048;
   localparam int POS_W           = 12;
   localparam int HDR_BYTES       = 42;   // bytes 0..41 cover ARP and IPv4 headers
   localparam int L4_BYTES        = 8;

   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [31:0] BROADCAST_IP   = 32'hFFFF_FFFF;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
   localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
   localparam logic [15:0] ARP_OPCODE_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OPCODE_REPLY   = 16'd2;

   typedef enum logic [0:0] {
      CSR_LOCAL_IP   = 1'b0,
      CSR_GATEWAY_IP = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      V_DROP      = 4'd0,
      V_ARP_REQ   = 4'd1,
      V_ARP_REP   = 4'd2,
      V_ARP_OTHER = 4'd3,
      V_ECHO_REQ  = 4'd4,
      V_ECHO_REP  = 4'd5,
      V_ICMP      = 4'd6,
      V_UDP       = 4'd7,
      V_IP_OTHER  = 4'd8
   } verdict_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  verdict;
      logic [31:0] peer_ip;
      logic [47:0] peer_mac;
      logic        to_broadcast;
      logic [15:0] icmp_ident;
      logic [15:0] icmp_sequence;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [11:0] payload_offset;
      logic [11:0] payload_length;
      logic [47:0] gateway_mac;
      logic        gateway_mac_valid;
   } rsp_type;

   // Captured frame handed from the capture stage to the classifier
   typedef struct packed {
      logic                             valid;
      logic [POS_W-1:0]                 len;
      logic [HDR_BYTES-1:0][7:0]        hdr;
      logic [L4_BYTES-1:0][7:0]         l4;
   } cap_type;

endpackage

>>> rtl/core/eac_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_capture
// Counts frame bytes and captures fixed header bytes and the first eight
// bytes after the IPv4 header; holds a finished frame until it is classified.
// ----------------------------------------------------------------------------
module eac_capture (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  eac_pkg::req_type  item,
   input  logic              drain,
   output eac_pkg::cap_type  cap
);

   logic [eac_pkg::POS_W-1:0]                    pos_ff, pos_in;
   logic                                         pend_ff, pend_in;
   logic [eac_pkg::POS_W-1:0]                    len_ff, len_in;
   logic [eac_pkg::HDR_BYTES-1:0][7:0]           hdr_ff, hdr_in;
   logic [eac_pkg::L4_BYTES-1:0][7:0]            l4_ff, l4_in;
   logic                                         keep;
   logic [eac_pkg::POS_W-1:0]                    pos_inc;
   logic [eac_pkg::POS_W-1:0]                    l4_start;
   logic [eac_pkg::POS_W-1:0]                    l4_off;

   assign keep     = pos_ff < eac_pkg::POS_W'(eac_pkg::MAX_FRAME_BYTES);
   assign pos_inc  = keep ? pos_ff + eac_pkg::POS_W'(1) : pos_ff;
   // transport header starts at 14 + 4 * IHL
   assign l4_start = eac_pkg::POS_W'(14) + {{(eac_pkg::POS_W-6){1'b0}}, hdr_ff[14][3:0], 2'b00};
   assign l4_off   = pos_ff - l4_start;

   // Store the byte at its fixed place and advance the position
   always_comb begin
      pos_in  = pos_ff;
      pend_in = pend_ff & ~drain;
      len_in  = len_ff;
      hdr_in  = hdr_ff;
      l4_in   = l4_ff;
      if (accept) begin
         if (keep && pos_ff < eac_pkg::POS_W'(eac_pkg::HDR_BYTES)) begin
            hdr_in[pos_ff[5:0]] = item.frame_byte;
         end
         if (keep && pos_ff >= l4_start && l4_off < eac_pkg::POS_W'(eac_pkg::L4_BYTES)) begin
            l4_in[l4_off[2:0]] = item.frame_byte;
         end
         if (item.last_byte) begin
            pos_in  = '0;
            pend_in = 1'b1;
            len_in  = pos_inc;
         end else begin
            pos_in = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
      end
      len_ff <= len_in;
      hdr_ff <= hdr_in;
      l4_ff  <= l4_in;
   end

   assign cap.valid = pend_ff;
   assign cap.len   = len_ff;
   assign cap.hdr   = hdr_ff;
   assign cap.l4    = l4_ff;

endmodule

>>> rtl/core/eth_arp_ipv4_rx_classifier.sv
`timescale 1ns / 1ps
// Path: the last byte of a frame sets the held capture, which is drained into the result
//   register once the output is free; the result item is then taken from there.
// Throughput: one byte per cycle; a frame of one byte may follow another at once.
//   Input stalls only while a finished frame waits behind a result item not yet taken.
// Reset clears byte position, pending verdict, result valid and learned gateway MAC;
// local_ip resets to 10.0.2.15 and gateway_ip to 10.0.2.2.
// ----------------------------------------------------------------------------
// eth_arp_ipv4_rx_classifier
// Classifies received Ethernet frames as ARP or IPv4 ICMP / UDP and learns
// the gateway hardware address from ARP traffic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module eth_arp_ipv4_rx_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eac_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output eac_pkg::rsp_type  rsp_item,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   eac_pkg::cap_type cap;
   logic             out_free, drain;
   logic [31:0]      local_ip_ff, gateway_ip_ff;
   logic [47:0]      gw_mac_ff, gw_mac_in;
   logic             gw_valid_ff, gw_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   eac_pkg::rsp_type rsp_ff, rsp_in;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign drain     = cap.valid & out_free;
   assign req_ready = ~cap.valid | out_free;

   eac_capture u_capture (
      .clock  (clock),
      .reset  (reset),
      .accept (req_valid & req_ready),
      .item   (req_item),
      .drain  (drain),
      .cap    (cap)
   );

   // Header fields at fixed offsets
   logic [11:0] plen;
   logic [15:0] etype, htype, ptype, arp_op, ip_total;
   logic [47:0] sha;
   logic [31:0] spa, tpa, ip_src, ip_dst;
   logic [5:0]  ihl;
   logic [15:0] total, ilen, room, ulen, upl;
   logic [11:0] l4_pos;
   logic        arp_ok, ip_ok, dst_ok, is_bcast, learn;

   assign plen     = cap.len - 12'd14;
   assign etype    = {cap.hdr[12], cap.hdr[13]};
   assign htype    = {cap.hdr[14], cap.hdr[15]};
   assign ptype    = {cap.hdr[16], cap.hdr[17]};
   assign arp_op   = {cap.hdr[20], cap.hdr[21]};
   assign sha      = {cap.hdr[22], cap.hdr[23], cap.hdr[24], cap.hdr[25], cap.hdr[26],
                      cap.hdr[27]};
   assign spa      = {cap.hdr[28], cap.hdr[29], cap.hdr[30], cap.hdr[31]};
   assign tpa      = {cap.hdr[38], cap.hdr[39], cap.hdr[40], cap.hdr[41]};
   assign ip_total = ptype;
   assign ip_src   = {cap.hdr[26], cap.hdr[27], cap.hdr[28], cap.hdr[29]};
   assign ip_dst   = {cap.hdr[30], cap.hdr[31], cap.hdr[32], cap.hdr[33]};
   assign ihl      = {cap.hdr[14][3:0], 2'b00};
   assign l4_pos   = 12'd14 + {6'd0, ihl};

   assign arp_ok = cap.len >= 12'd42 && etype == eac_pkg::ETHERTYPE_ARP &&
                   htype == 16'd1 && ptype == eac_pkg::ETHERTYPE_IPV4 &&
                   cap.hdr[18] == 8'd6 && cap.hdr[19] == 8'd4;
   assign ip_ok  = cap.len >= 12'd34 && etype == eac_pkg::ETHERTYPE_IPV4 &&
                   cap.hdr[14][7:4] == 4'd4 && ihl >= 6'd20 && plen >= {6'd0, ihl};
   assign is_bcast = ip_dst == eac_pkg::BROADCAST_IP;
   assign dst_ok   = ip_dst == local_ip_ff || is_bcast;
   assign learn    = drain && arp_ok && spa == gateway_ip_ff;

   // Clamp total length, then derive ICMP and UDP lengths
   assign total = (ip_total < {10'd0, ihl} || ip_total > {4'd0, plen}) ? {4'd0, plen}
                                                                      : ip_total;
   assign ilen  = total - {10'd0, ihl};
   assign room  = ilen - 16'd8;
   assign ulen  = {cap.l4[4], cap.l4[5]};
   assign upl   = (ulen > 16'd8) ? ((ulen - 16'd8 > room) ? room : ulen - 16'd8) : 16'd0;

   assign gw_mac_in   = learn ? sha : gw_mac_ff;
   assign gw_valid_in = learn | gw_valid_ff;

   // Build the verdict of the held frame
   always_comb begin
      rsp_in = '0;
      rsp_in.verdict = eac_pkg::V_DROP;
      if (arp_ok) begin
         if (arp_op == eac_pkg::ARP_OPCODE_REQUEST && tpa == local_ip_ff) begin
            rsp_in.verdict = eac_pkg::V_ARP_REQ;
         end else if (arp_op == eac_pkg::ARP_OPCODE_REPLY && tpa == local_ip_ff) begin
            rsp_in.verdict = eac_pkg::V_ARP_REP;
         end else begin
            rsp_in.verdict = eac_pkg::V_ARP_OTHER;
         end
         rsp_in.peer_ip  = spa;
         rsp_in.peer_mac = sha;
      end else if (ip_ok && dst_ok) begin
         rsp_in.peer_ip      = ip_src;
         rsp_in.to_broadcast = is_bcast;
         if (cap.hdr[23] == eac_pkg::PROTO_ICMP) begin
            rsp_in.verdict = eac_pkg::V_ICMP;
            if (ilen >= 16'd8) begin
               if (cap.l4[0] == eac_pkg::ICMP_ECHO_REQ) begin
                  rsp_in.verdict = eac_pkg::V_ECHO_REQ;
               end else if (cap.l4[0] == eac_pkg::ICMP_ECHO_REP) begin
                  rsp_in.verdict = eac_pkg::V_ECHO_REP;
               end
               rsp_in.icmp_ident     = {cap.l4[4], cap.l4[5]};
               rsp_in.icmp_sequence  = {cap.l4[6], cap.l4[7]};
               rsp_in.payload_offset = l4_pos + 12'd8;
               rsp_in.payload_length = room[11:0];
            end
         end else if (cap.hdr[23] == eac_pkg::PROTO_UDP && ilen > 16'd8) begin
            rsp_in.verdict        = eac_pkg::V_UDP;
            rsp_in.source_port    = {cap.l4[0], cap.l4[1]};
            rsp_in.dest_port      = {cap.l4[2], cap.l4[3]};
            rsp_in.payload_offset = l4_pos + 12'd8;
            rsp_in.payload_length = upl[11:0];
         end else begin
            rsp_in.verdict = eac_pkg::V_IP_OTHER;
         end
      end
      rsp_in.gateway_mac       = gw_mac_in;
      rsp_in.gateway_mac_valid = gw_valid_in;
   end

   // Hold the result until taken
   assign rsp_valid_in = drain | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         gw_mac_ff     <= '0;
         gw_valid_ff   <= 1'b0;
         local_ip_ff   <= 32'd167772687;
         gateway_ip_ff <= 32'd167772674;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         gw_mac_ff    <= gw_mac_in;
         gw_valid_ff  <= gw_valid_in;
         if (csr_we && csr_index == eac_pkg::CSR_LOCAL_IP) begin
            local_ip_ff <= csr_wdata;
         end
         if (csr_we && csr_index == eac_pkg::CSR_GATEWAY_IP) begin
            gateway_ip_ff <= csr_wdata;
         end
      end
      if (drain) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Result checks: verdict in range, sender MAC only on ARP verdicts
   logic verdict_legal, mac_legal;
   assign verdict_legal = rsp_ff.verdict <= eac_pkg::V_IP_OTHER;
   assign mac_legal     = rsp_ff.verdict <= eac_pkg::V_ARP_OTHER || rsp_ff.peer_mac == '0;

   `ASSERT_ALWAYS(a_verdict_range, clock, reset, !rsp_valid_ff || verdict_legal)
   `ASSERT_NEVER(a_learn_sticky, clock, reset, $fell(gw_valid_ff))
   `ASSERT_ALWAYS(a_mac_only_arp, clock, reset, !rsp_valid_ff || mac_legal)
   `ASSERT_ALWAYS(a_drain_fills, clock, reset, drain |=> rsp_valid_ff)

endmodule

>>> tb/eth_arp_ipv4_rx_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_arp_ipv4_rx_classifier_tb
// Sends whole Ethernet frames byte by byte: hand-built ARP, ICMP and UDP frames,
// malformed headers, short and oversized frames, then random traffic under
// several address settings. A local classifier computes the verdict of each
// frame and every result item is compared field by field in order.
// ----------------------------------------------------------------------------
module eth_arp_ipv4_rx_classifier_tb;
   import eac_pkg::*;

   typedef logic [7:0] frame_t[$];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;
   logic    csr_we = 1'b0;
   logic [0:0]  csr_index = CSR_LOCAL_IP;
   logic [31:0] csr_wdata = '0;

   // classifier state kept by the bench
   logic [31:0] own_ip = 32'h0A00020F;
   logic [31:0] gw_ip  = 32'h0A000202;
   logic [7:0]  capture [96];
   int unsigned frame_pos = 0;
   int unsigned bytes_sent = 0;
   logic [47:0] gw_mac = '0;
   logic        gw_mac_ok = 1'b0;

   rsp_type     verdicts_due[$];
   int          errors = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_cnt = 0;

   eth_arp_ipv4_rx_classifier DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- prediction
   function automatic logic [7:0] rd8(int unsigned off);
      return (off < 96) ? capture[off] : 8'h00;
   endfunction

   function automatic logic [15:0] rd16(int unsigned off);
      return {rd8(off), rd8(off + 1)};
   endfunction

   function automatic logic [31:0] rd32(int unsigned off);
      return {rd16(off), rd16(off + 2)};
   endfunction

   function automatic rsp_type classify_frame(int unsigned len);
      rsp_type     r;
      int unsigned plen, ihl, total, l4, ilen, room, ulen, pl;
      logic [47:0] sha;
      logic [31:0] spa, tpa, dst;
      logic [15:0] op;
      logic [7:0]  vi, proto, icmp_kind;
      r = '0;
      if (len >= 14) begin
         plen = len - 14;
         if (rd16(12) == ETHERTYPE_ARP) begin
            if (plen >= 28 && rd16(14) == 16'd1 && rd16(16) == ETHERTYPE_IPV4 &&
                rd8(18) == 8'd6 && rd8(19) == 8'd4) begin
               op  = rd16(20);
               sha = {rd16(22), rd32(24)};
               spa = rd32(28);
               tpa = rd32(38);
               // learn the gateway address from any valid ARP it sends
               if (spa == gw_ip) begin
                  gw_mac    = sha;
                  gw_mac_ok = 1'b1;
               end
               if (op == ARP_OPCODE_REQUEST && tpa == own_ip) r.verdict = V_ARP_REQ;
               else if (op == ARP_OPCODE_REPLY && tpa == own_ip) r.verdict = V_ARP_REP;
               else r.verdict = V_ARP_OTHER;
               r.peer_ip  = spa;
               r.peer_mac = sha;
            end
         end else if (rd16(12) == ETHERTYPE_IPV4 && plen >= 20) begin
            vi  = rd8(14);
            ihl = vi[3:0] * 4;
            if (vi[7:4] == 4'd4 && ihl >= 20 && plen >= ihl) begin
               total = rd16(16);
               dst   = rd32(30);
               proto = rd8(23);
               l4    = 14 + ihl;
               if (total < ihl || total > plen) total = plen;
               if (dst == own_ip || dst == BROADCAST_IP) begin
                  r.peer_ip      = rd32(26);
                  r.to_broadcast = (dst == BROADCAST_IP);
                  if (proto == PROTO_ICMP) begin
                     ilen = total - ihl;
                     r.verdict = V_ICMP;
                     if (ilen >= 8) begin
                        icmp_kind = rd8(l4);
                        if (icmp_kind == ICMP_ECHO_REQ) r.verdict = V_ECHO_REQ;
                        else if (icmp_kind == ICMP_ECHO_REP) r.verdict = V_ECHO_REP;
                        r.icmp_ident     = rd16(l4 + 4);
                        r.icmp_sequence  = rd16(l4 + 6);
                        r.payload_offset = 12'(l4 + 8);
                        r.payload_length = 12'(ilen - 8);
                     end
                  end else if (proto == PROTO_UDP && total > ihl + 8) begin
                     room = total - ihl - 8;
                     ulen = rd16(l4 + 4);
                     pl   = (ulen > 8) ? ulen - 8 : 0;
                     if (pl > room) pl = room;
                     r.verdict        = V_UDP;
                     r.source_port    = rd16(l4);
                     r.dest_port      = rd16(l4 + 2);
                     r.payload_offset = 12'(l4 + 8);
                     r.payload_length = 12'(pl);
                  end else begin
                     r.verdict = V_IP_OTHER;
                  end
               end
            end
         end
      end
      r.gateway_mac       = gw_mac;
      r.gateway_mac_valid = gw_mac_ok;
      return r;
   endfunction

   // Keep the byte and, on the last one, queue the frame's verdict
   task automatic note_byte(logic [7:0] b, logic last);
      bytes_sent++;
      if (frame_pos < MAX_FRAME_BYTES) begin
         if (frame_pos < 96) capture[frame_pos] = b;
         frame_pos++;
      end
      if (last) begin
         verdicts_due.push_back(classify_frame(frame_pos));
         frame_pos = 0;
      end
   endtask

   // ---------------------------------------------------------------- driving
   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_item  <= '{frame_byte: b, last_byte: last};
      do @(posedge clock); while (!req_ready);
      note_byte(b, last);
      burst_left--;
   endtask

   task automatic send_frame(frame_t q);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   // Drain all verdicts and let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_addresses(logic [31:0] lip, logic [31:0] gip);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_LOCAL_IP;
      csr_wdata <= lip;
      @(posedge clock);
      csr_index <= CSR_GATEWAY_IP;
      csr_wdata <= gip;
      @(posedge clock);
      csr_we <= 1'b0;
      own_ip = lip;
      gw_ip  = gip;
   endtask

   // ---------------------------------------------------------------- frame building
   function automatic void put(ref frame_t q, input logic [47:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_rand(ref frame_t q, input int n);
      repeat (n) q.push_back(8'($urandom));
   endfunction

   function automatic frame_t eth_frame(logic [15:0] etype);
      frame_t q;
      put_rand(q, 12);
      put(q, etype, 2);
      return q;
   endfunction

   // A negative pad cuts that many bytes off the end of the packet
   function automatic frame_t arp_frame(logic [15:0] htype, logic [15:0] ptype,
                                        logic [7:0] hlen, logic [7:0] alen,
                                        logic [15:0] op, logic [47:0] sha,
                                        logic [31:0] spa, logic [31:0] tpa, int pad);
      frame_t q;
      q = eth_frame(ETHERTYPE_ARP);
      put(q, htype, 2);
      put(q, ptype, 2);
      put(q, hlen, 1);
      put(q, alen, 1);
      put(q, op, 2);
      put(q, sha, 6);
      put(q, spa, 4);
      put_rand(q, 6);
      put(q, tpa, 4);
      if (pad < 0) begin
         repeat (-pad) void'(q.pop_back());
      end else begin
         put_rand(q, pad);
      end
      return q;
   endfunction

   function automatic frame_t ip_frame(logic [3:0] ver, logic [3:0] ihl_w, logic [7:0] proto,
                                       logic [31:0] src, logic [31:0] dst, frame_t l4,
                                       int total_adj, int pad);
      frame_t q;
      q = eth_frame(ETHERTYPE_IPV4);
      put(q, {ver, ihl_w}, 1);
      put_rand(q, 1);
      put(q, 48'(ihl_w * 4 + l4.size() + total_adj), 2);
      put_rand(q, 5);
      put(q, proto, 1);
      put_rand(q, 2);
      put(q, src, 4);
      put(q, dst, 4);
      if (ihl_w > 5) put_rand(q, ihl_w * 4 - 20);
      q = {q, l4};
      put_rand(q, pad);
      return q;
   endfunction

   function automatic frame_t icmp_msg(logic [7:0] kind, logic [15:0] ident,
                                       logic [15:0] seqno, int n);
      frame_t q;
      put(q, kind, 1);
      put_rand(q, 3);
      put(q, ident, 2);
      put(q, seqno, 2);
      put_rand(q, n);
      return q;
   endfunction

   function automatic frame_t udp_msg(logic [15:0] sp, logic [15:0] dp,
                                      logic [15:0] ulen, int n);
      frame_t q;
      put(q, sp, 2);
      put(q, dp, 2);
      put(q, ulen, 2);
      put_rand(q, 2);
      put_rand(q, n);
      return q;
   endfunction

   function automatic frame_t noise_frame(int n);
      frame_t q;
      put_rand(q, n);
      return q;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic chk(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            $error("result item with no frame pending");
            errors++;
         end else begin
            e = verdicts_due.pop_front();
            chk("verdict", e.verdict, rsp_item.verdict);
            chk("peer_ip", e.peer_ip, rsp_item.peer_ip);
            chk("peer_mac", e.peer_mac, rsp_item.peer_mac);
            chk("to_broadcast", e.to_broadcast, rsp_item.to_broadcast);
            chk("icmp_ident", e.icmp_ident, rsp_item.icmp_ident);
            chk("icmp_sequence", e.icmp_sequence, rsp_item.icmp_sequence);
            chk("source_port", e.source_port, rsp_item.source_port);
            chk("dest_port", e.dest_port, rsp_item.dest_port);
            chk("payload_offset", e.payload_offset, rsp_item.payload_offset);
            chk("payload_length", e.payload_length, rsp_item.payload_length);
            chk("gateway_mac", e.gateway_mac, rsp_item.gateway_mac);
            chk("gateway_mac_valid", e.gateway_mac_valid, rsp_item.gateway_mac_valid);
         end
      end
   end

   // Receiver stalls: always ready, light stalls or heavy stalls, in stretches
   always @(posedge clock) begin
      if (stall_cnt == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_cnt  = $urandom_range(20, 200);
      end
      stall_cnt--;
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 2) == 0);
         end
      endcase
   end

   // ---------------------------------------------------------------- tests
   task automatic test_short_frames();
      send_frame(noise_frame(1));
      send_frame(noise_frame(13));
      send_frame(eth_frame(ETHERTYPE_IPV4));
      send_frame({eth_frame(16'h86DD), noise_frame(40)});
      send_frame({eth_frame(16'hFFFF), noise_frame(2)});
   endtask

   task automatic test_arp();
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REQUEST, 48'hFFFF_FFFF_FFFF,
                           32'hFFFF_FFFF, own_ip, 0));
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REPLY, 48'h0,
                           32'h0, own_ip, 4));
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 4, 16'h0003, 48'h1234_5678_9ABC,
                           32'h0A00_0203, own_ip, 0));
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REQUEST, 48'h0200_0000_0001,
                           32'h0A00_0203, ~own_ip, 0));
   endtask

   task automatic test_arp_malformed();
      frame_t q;
      send_frame(arp_frame(2, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REQUEST, 48'h5, gw_ip,
                           own_ip, 0));
      send_frame(arp_frame(1, 16'h86DD, 6, 4, ARP_OPCODE_REQUEST, 48'h5, gw_ip, own_ip, 0));
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 8, 4, ARP_OPCODE_REQUEST, 48'h5, gw_ip,
                           own_ip, 0));
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 16, ARP_OPCODE_REQUEST, 48'h5, gw_ip,
                           own_ip, 0));
      // one payload byte short of a full ARP packet
      q = arp_frame(1, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REQUEST, 48'h5, gw_ip, own_ip, 0);
      void'(q.pop_back());
      send_frame(q);
   endtask

   task automatic test_gateway_learning();
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REPLY, 48'hAABB_CCDD_EEFF,
                           gw_ip, own_ip, 0));
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REQUEST, 48'h1122_3344_5566,
                           gw_ip, 32'h0A00_0299, 0));
      send_frame(arp_frame(1, ETHERTYPE_IPV4, 6, 4, ARP_OPCODE_REQUEST, 48'h7777_7777_7777,
                           gw_ip + 1, own_ip, 0));
   endtask

   task automatic test_icmp();
      send_frame(ip_frame(4, 5, PROTO_ICMP, 32'h0A00_0202, own_ip,
                          icmp_msg(ICMP_ECHO_REQ, 16'hFFFF, 16'h0000, 16), 0, 0));
      send_frame(ip_frame(4, 5, PROTO_ICMP, 32'hFFFF_FFFF, BROADCAST_IP,
                          icmp_msg(ICMP_ECHO_REP, 16'h0000, 16'hFFFF, 0), 0, 6));
      send_frame(ip_frame(4, 7, PROTO_ICMP, 32'h0, own_ip,
                          icmp_msg(8'd3, 16'h1234, 16'h5678, 4), 0, 0));
      // fewer than eight ICMP bytes
      send_frame(ip_frame(4, 5, PROTO_ICMP, 32'h0101_0101, own_ip, noise_frame(7), 0, 0));
      // total length beyond payload and below header length
      send_frame(ip_frame(4, 5, PROTO_ICMP, 32'h0202_0202, own_ip,
                          icmp_msg(ICMP_ECHO_REQ, 16'h1, 16'h2, 10), 40, 0));
      send_frame(ip_frame(4, 6, PROTO_ICMP, 32'h0303_0303, own_ip,
                          icmp_msg(ICMP_ECHO_REQ, 16'h3, 16'h4, 10), -30, 3));
   endtask

   task automatic test_udp();
      send_frame(ip_frame(4, 5, PROTO_UDP, 32'h0A00_0202, own_ip,
                          udp_msg(16'hFFFF, 16'h0000, 16'd18, 10), 0, 0));
      send_frame(ip_frame(4, 15, PROTO_UDP, 32'hC0A8_0001, BROADCAST_IP,
                          udp_msg(16'h0044, 16'h0043, 16'd8, 5), 0, 2));
      send_frame(ip_frame(4, 5, PROTO_UDP, 32'h1, own_ip,
                          udp_msg(16'h1, 16'h2, 16'hFFFF, 6), 0, 0));
      send_frame(ip_frame(4, 5, PROTO_UDP, 32'h2, own_ip,
                          udp_msg(16'h3, 16'h4, 16'd0, 6), -6, 6));
      // header only: no room for a payload
      send_frame(ip_frame(4, 5, PROTO_UDP, 32'h3, own_ip, udp_msg(16'h5, 16'h6, 16'd8, 0),
                          0, 0));
      send_frame(ip_frame(4, 5, 8'd6, 32'h4, own_ip, noise_frame(20), 0, 0));
   endtask

   task automatic test_ipv4_malformed();
      send_frame(ip_frame(6, 5, PROTO_UDP, 32'h5, own_ip, udp_msg(1, 2, 12, 4), 0, 0));
      send_frame(ip_frame(4, 4, PROTO_UDP, 32'h5, own_ip, udp_msg(1, 2, 12, 4), 0, 0));
      send_frame(ip_frame(4, 15, PROTO_ICMP, 32'h5, own_ip, noise_frame(0), 0, 0));
      send_frame(ip_frame(4, 5, PROTO_ICMP, 32'h5, own_ip ^ 32'h1,
                          icmp_msg(ICMP_ECHO_REQ, 1, 2, 0), 0, 0));
      send_frame({eth_frame(ETHERTYPE_IPV4), 8'h45, noise_frame(18)});
   endtask

   task automatic test_long_frame();
      send_frame(ip_frame(4, 5, PROTO_UDP, 32'h0A0B_0C0D, own_ip,
                          udp_msg(16'h2222, 16'h3333, 16'd3000, 2100), 0, 0));
      send_frame(noise_frame(2200));
   endtask

   task automatic random_frame();
      frame_t      l4;
      logic [31:0] spa, tpa, dst;
      int          pick, bad;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         // ARP, half of it malformed
         case ($urandom_range(0, 2))
            0: spa = gw_ip;
            1: spa = own_ip;
            default: spa = $urandom;
         endcase
         tpa = ($urandom_range(0, 2) != 0) ? own_ip : $urandom;
         bad = $urandom_range(0, 9);
         send_frame(arp_frame((bad == 0) ? 16'($urandom) : 16'd1,
                              (bad == 1) ? 16'($urandom) : ETHERTYPE_IPV4,
                              (bad == 2) ? 8'($urandom) : 8'd6,
                              (bad == 3) ? 8'($urandom) : 8'd4,
                              ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(1, 2)),
                              48'({$urandom, $urandom}), spa, tpa,
                              (bad == 4) ? -int'($urandom_range(1, 8))
                                         : int'($urandom_range(0, 8))));
      end else if (pick < 85) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: dst = own_ip;
            5, 6, 7, 8: dst = BROADCAST_IP;
            default: dst = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0, 1: l4 = icmp_msg(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                : ($urandom_range(0, 1) ? ICMP_ECHO_REQ : ICMP_ECHO_REP),
                                $urandom, $urandom, $urandom_range(0, 24));
            2, 3: begin
               bad = $urandom_range(0, 24);
               l4  = udp_msg($urandom, $urandom,
                             ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 50))
                                                         : 16'(bad + 8), bad);
            end
            default: l4 = noise_frame($urandom_range(0, 30));
         endcase
         send_frame(ip_frame(($urandom_range(0, 14) == 0) ? 4'($urandom) : 4'd4,
                             ($urandom_range(0, 3) == 0) ? 4'($urandom_range(3, 15)) : 4'd5,
                             (l4.size() >= 8 && $urandom_range(0, 4) != 0)
                                ? (($urandom_range(0, 1)) ? PROTO_ICMP : PROTO_UDP)
                                : 8'($urandom),
                             $urandom, dst, l4,
                             ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 60)) - 30 : 0,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0));
      end else begin
         send_frame(noise_frame($urandom_range(1, 60)));
      end
   endtask

   // At least 390 bytes and four random frames under each address setting
   task automatic test_random_traffic();
      int unsigned start;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_addresses(32'h0000_0000, 32'h0000_0000);
            1: set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: set_addresses($urandom, $urandom);
            default: set_addresses(32'h0A00_020F, 32'hFFFF_FFFF);
         endcase
         start = bytes_sent;
         for (int n = 0; bytes_sent - start < 390 || n < 4; n++) begin
            random_frame();
         end
      end
   endtask

   initial begin
      foreach (capture[i]) capture[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_frames();
      test_arp();
      test_arp_malformed();
      test_gateway_learning();
      test_icmp();
      test_udp();
      test_ipv4_malformed();
      test_long_frame();
      test_random_traffic();
      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> eth_arp_ipv4_rx_classifier.f
+incdir+rtl/core
rtl/core/eac_pkg.sv
rtl/core/eac_capture.sv
rtl/core/eth_arp_ipv4_rx_classifier.sv
tb/eth_arp_ipv4_rx_classifier_tb.sv
